/* rtl/core/conv5_pkg.sv */
package conv5_pkg;

   localparam int KSIZE      = 5;
   localparam int HALF       = KSIZE / 2;
   localparam int RING_ROWS  = KSIZE + 2;
   localparam int SLOT_W     = 3;
   localparam int NUM_CH     = 3;
   localparam int CH_W       = 8;
   localparam int PIX_W      = NUM_CH * CH_W;
   localparam int PIX_MAX    = 255;
   localparam int COEF_W     = 12;
   localparam int COEF_ROW_W = KSIZE * COEF_W;
   localparam int ROW_W      = 12;
   localparam int SHIFT_W    = 4;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = COEF_ROW_W;
   localparam int PROD_W     = 21;
   localparam int RSUM_W     = 24;
   localparam int SUM_W      = 27;
   localparam int POS_W      = 3;

   typedef logic [PIX_W-1:0]      pix_type;
   typedef logic [COEF_ROW_W-1:0] coef_row_type;
   typedef logic [CH_W-1:0]       chan_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COEF_ROW0    = 4'd0,
      REG_COEF_ROW1    = 4'd1,
      REG_COEF_ROW2    = 4'd2,
      REG_COEF_ROW3    = 4'd3,
      REG_COEF_ROW4    = 4'd4,
      REG_NORM_SHIFT   = 4'd5,
      REG_FRAME_WIDTH  = 4'd6,
      REG_FRAME_HEIGHT = 4'd7
   } csr_reg_type;

   localparam coef_row_type COEF_ROW2_RESET = 60'd16777216;
   localparam logic [ROW_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd480;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

endpackage

/* rtl/core/conv5_ifs.sv */
interface conv5_req_if;
   import conv5_pkg::*;
   logic     valid;
   logic     ready;
   chan_type pix_blue;
   chan_type pix_green;
   chan_type pix_red;
   logic     flush;
   modport source (output valid, output pix_blue, output pix_green, output pix_red,
                   output flush, input ready);
   modport sink (input valid, input pix_blue, input pix_green, input pix_red,
                 input flush, output ready);
endinterface

interface conv5_rsp_if;
   import conv5_pkg::*;
   logic     valid;
   logic     ready;
   chan_type out_blue;
   chan_type out_green;
   chan_type out_red;
   logic     frame_end;
   modport source (output valid, output out_blue, output out_green, output out_red,
                   output frame_end, input ready);
   modport sink (input valid, input out_blue, input out_green, input out_red,
                 input frame_end, output ready);
endinterface

interface conv5_csr_if;
   import conv5_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/conv5x5_rgb_replicate_top.sv */
// Streaming 5x5 convolution of RGB pixels in raster order, one kernel shared by the three
// channels, replicated borders, round-half-up shift and clamp to 0..255. One word is taken
// every clock while the result side keeps up; the result for a pixel leaves once the pixel
// two rows and two columns ahead of it has been taken, then passes through the pipeline
// registers (row RAM read, window, tap select, multiply, row sums, total, output register).
// After the frame's pixels, 2*width+2 further words (flush or not) drain the frame;
// flush words before the frame is complete are dropped. Seven row RAMs of MAX_WIDTH
// pixels hold the frame's recent rows; frame geometry is latched on the frame's first
// word, coefficients and shift apply as written. Write configuration only while idle.
module conv5x5_rgb_replicate_top #(
   parameter int MAX_WIDTH = 2048
) (
   input logic        clock,
   input logic        reset,
   conv5_req_if.sink  req_bus,
   conv5_rsp_if.source rsp_bus,
   conv5_csr_if.sink  csr_bus
);
   import conv5_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int PW = WW + 2;
   localparam int CS = WW + 2;

   // configuration
   coef_row_type        coef_ff [KSIZE];
   logic [SHIFT_W-1:0]  norm_ff;
   logic [ROW_W-1:0]    fw_ff, fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < KSIZE; r++) begin
            coef_ff[r] <= '0;
         end
         coef_ff[2] <= COEF_ROW2_RESET;
         norm_ff    <= '0;
         fw_ff      <= WIDTH_RESET;
         fh_ff      <= HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index) inside
            [REG_COEF_ROW0:REG_COEF_ROW4]: coef_ff[csr_bus.index[2:0]] <= csr_bus.data;
            REG_NORM_SHIFT:   norm_ff <= csr_bus.data[SHIFT_W-1:0];
            REG_FRAME_WIDTH:  fw_ff   <= csr_bus.data[ROW_W-1:0];
            REG_FRAME_HEIGHT: fh_ff   <= csr_bus.data[ROW_W-1:0];
            default: ;
         endcase
      end
   end
   assign csr_bus.ready = 1'b1;

   // frame control
   logic                active_ff, active_in;
   logic [WW-1:0]       cw_ff, cw_in;
   logic [ROW_W-1:0]    ch_ff, ch_in;
   logic [AW-1:0]       icol_ff, icol_in;
   logic [ROW_W-1:0]    irow_ff, irow_in;
   logic [SLOT_W-1:0]   islot_ff, islot_in;
   logic [PW-1:0]       pre_ff, pre_in;
   logic [AW-1:0]       fcol_ff, fcol_in;
   logic [ROW_W-1:0]    frow_ff, frow_in;
   logic [SLOT_W-1:0]   fslot_ff, fslot_in;
   logic [AW-1:0]       ocol_ff, ocol_in;
   logic [ROW_W-1:0]    orow_ff, orow_in;

   logic                advance, accept, in_phase, counted, wr_en, fetch, has_out, last;
   logic [WW-1:0]       w_new, w_cur, wm1;
   logic [ROW_W-1:0]    h_new, h_cur, hm1;
   logic [PW-1:0]       two_w;
   pix_type             pix_in;
   logic [SLOT_W-1:0]   slot_sel [KSIZE];
   logic                byp_sel [KSIZE];
   logic [POS_W-1:0]    pos_sel [KSIZE];
   logic signed [13:0]  rr, efull, hm1_s;
   logic signed [4:0]   sacc;
   logic signed [CS-1:0] cc, wm1_s, oc_s;

   assign req_bus.ready = advance;
   assign accept = req_bus.valid && advance;
   assign pix_in = {req_bus.pix_red, req_bus.pix_green, req_bus.pix_blue};

   always_comb begin
      if (fw_ff == '0) begin
         w_new = WW'(1);
      end else if (int'(fw_ff) > MAX_WIDTH) begin
         w_new = WW'(MAX_WIDTH);
      end else begin
         w_new = WW'(fw_ff);
      end
      h_new    = (fh_ff == '0) ? ROW_W'(1) : fh_ff;
      w_cur    = active_ff ? cw_ff : w_new;
      h_cur    = active_ff ? ch_ff : h_new;
      wm1      = w_cur - WW'(1);
      hm1      = h_cur - ROW_W'(1);
      two_w    = PW'({w_cur, 1'b0});
      in_phase = irow_ff < h_cur;
      counted  = accept && !(in_phase && req_bus.flush);
      wr_en    = counted && in_phase;
      fetch    = counted && (pre_ff >= two_w) && (frow_ff < h_cur);
      has_out  = counted && (pre_ff >= two_w + PW'(2));
      last     = (orow_ff == hm1) && (WW'(ocol_ff) == wm1);

      active_in = active_ff;
      cw_in     = cw_ff;
      ch_in     = ch_ff;
      if (accept && !active_ff) begin
         active_in = 1'b1;
         cw_in     = w_new;
         ch_in     = h_new;
      end

      icol_in  = icol_ff;
      irow_in  = irow_ff;
      islot_in = islot_ff;
      if (wr_en) begin
         if (WW'(icol_ff) == wm1) begin
            icol_in  = '0;
            irow_in  = irow_ff + ROW_W'(1);
            islot_in = (islot_ff == SLOT_W'(RING_ROWS - 1)) ? '0 : islot_ff + SLOT_W'(1);
         end else begin
            icol_in = icol_ff + AW'(1);
         end
      end

      pre_in = pre_ff;
      if (counted && !has_out) begin
         pre_in = pre_ff + PW'(1);
      end

      fcol_in  = fcol_ff;
      frow_in  = frow_ff;
      fslot_in = fslot_ff;
      if (fetch) begin
         if (WW'(fcol_ff) == wm1) begin
            fcol_in  = '0;
            frow_in  = frow_ff + ROW_W'(1);
            fslot_in = (fslot_ff == SLOT_W'(RING_ROWS - 1)) ? '0 : fslot_ff + SLOT_W'(1);
         end else begin
            fcol_in = fcol_ff + AW'(1);
         end
      end

      ocol_in = ocol_ff;
      orow_in = orow_ff;
      if (has_out) begin
         if (WW'(ocol_ff) == wm1) begin
            ocol_in = '0;
            orow_in = orow_ff + ROW_W'(1);
         end else begin
            ocol_in = ocol_ff + AW'(1);
         end
      end

      if (has_out && last) begin
         active_in = 1'b0;
         icol_in   = '0;
         irow_in   = '0;
         islot_in  = '0;
         pre_in    = '0;
         fcol_in   = '0;
         frow_in   = '0;
         fslot_in  = '0;
         ocol_in   = '0;
         orow_in   = '0;
      end

      // ring slot of each window row, clamped at the top and bottom edges
      hm1_s = $signed({2'b00, hm1});
      for (int d = 0; d < KSIZE; d++) begin
         rr = $signed({2'b00, frow_ff}) + 14'sd0 + 14'(d) - 14'(HALF);
         if (rr[13]) begin
            efull = 14'sd0 - $signed({2'b00, frow_ff});
         end else if (rr > hm1_s) begin
            efull = hm1_s - $signed({2'b00, frow_ff});
         end else begin
            efull = 14'(d) - 14'(HALF);
         end
         sacc = $signed({2'b00, fslot_ff}) + efull[4:0];
         if (sacc[4]) begin
            sacc = sacc + 5'sd7;
         end else if (sacc >= 5'sd7) begin
            sacc = sacc - 5'sd7;
         end
         slot_sel[d] = sacc[SLOT_W-1:0];
         byp_sel[d]  = wr_en && (sacc[SLOT_W-1:0] == islot_ff);
      end

      // window position of each kernel column, counted back from the newest column
      wm1_s = $signed(CS'(wm1));
      oc_s  = $signed(CS'(ocol_ff));
      for (int kc = 0; kc < KSIZE; kc++) begin
         cc = oc_s + CS'(kc) - CS'(HALF);
         if (cc[CS-1]) begin
            pos_sel[kc] = POS_W'(CS'(HALF) + oc_s);
         end else if (cc > wm1_s) begin
            pos_sel[kc] = POS_W'(CS'(HALF) - (wm1_s - oc_s));
         end else begin
            pos_sel[kc] = POS_W'(KSIZE - 1 - kc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cw_ff     <= WW'(1);
         ch_ff     <= ROW_W'(1);
         icol_ff   <= '0;
         irow_ff   <= '0;
         islot_ff  <= '0;
         pre_ff    <= '0;
         fcol_ff   <= '0;
         frow_ff   <= '0;
         fslot_ff  <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
      end else begin
         active_ff <= active_in;
         cw_ff     <= cw_in;
         ch_ff     <= ch_in;
         icol_ff   <= icol_in;
         irow_ff   <= irow_in;
         islot_ff  <= islot_in;
         pre_ff    <= pre_in;
         fcol_ff   <= fcol_in;
         frow_ff   <= frow_in;
         fslot_ff  <= fslot_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
      end
   end

   // row ring
   pix_type rdata [RING_ROWS];

   for (genvar i = 0; i < RING_ROWS; i++) begin : g_row
      conv5_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_row (
         .clock (clock),
         .we    (wr_en && (islot_ff == SLOT_W'(i))),
         .waddr (icol_ff),
         .wdata (pix_in),
         .re    (advance),
         .raddr (fcol_ff),
         .rdata (rdata[i])
      );
   end

   // stage 1: column assembly
   logic              s1_cnt_ff;
   ctl_type           s1_ctl_ff;
   logic [SLOT_W-1:0] s1_slot_ff [KSIZE];
   logic              s1_byp_ff [KSIZE];
   logic [POS_W-1:0]  s1_pos_ff [KSIZE];
   pix_type           s1_pix_ff;
   pix_type           col_in [KSIZE];

   // stage 2: window, stage 3: taps
   pix_type           win_ff [KSIZE][KSIZE];
   ctl_type           s2_ctl_ff;
   logic [POS_W-1:0]  s2_pos_ff [KSIZE];
   pix_type           tap_ff [KSIZE][KSIZE];
   ctl_type           s3_ctl_ff;
   ctl_type           lane_ctl_ff [3];

   always_comb begin
      for (int d = 0; d < KSIZE; d++) begin
         col_in[d] = s1_byp_ff[d] ? s1_pix_ff : rdata[s1_slot_ff[d]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_cnt_ff <= 1'b0;
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            lane_ctl_ff[i] <= '0;
         end
      end else if (advance) begin
         s1_cnt_ff      <= counted;
         s1_ctl_ff      <= '{valid: has_out, last: last};
         s2_ctl_ff      <= s1_ctl_ff;
         s3_ctl_ff      <= s2_ctl_ff;
         lane_ctl_ff[0] <= s3_ctl_ff;
         lane_ctl_ff[1] <= lane_ctl_ff[0];
         lane_ctl_ff[2] <= lane_ctl_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_slot_ff <= slot_sel;
         s1_byp_ff  <= byp_sel;
         s1_pos_ff  <= pos_sel;
         s1_pix_ff  <= pix_in;
         s2_pos_ff  <= s1_pos_ff;
         if (s1_cnt_ff) begin
            win_ff[0] <= col_in;
            for (int c = 1; c < KSIZE; c++) begin
               win_ff[c] <= win_ff[c-1];
            end
         end
         for (int kr = 0; kr < KSIZE; kr++) begin
            for (int kc = 0; kc < KSIZE; kc++) begin
               tap_ff[kr][kc] <= win_ff[s2_pos_ff[kc]][kr];
            end
         end
      end
   end

   // channel lanes
   chan_type lane_tap [NUM_CH][KSIZE][KSIZE];
   chan_type lane_res [NUM_CH];

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int kr = 0; kr < KSIZE; kr++) begin
            for (int kc = 0; kc < KSIZE; kc++) begin
               lane_tap[ch][kr][kc] = tap_ff[kr][kc][CH_W*ch +: CH_W];
            end
         end
      end
   end

   for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
      conv5_lane u_lane (
         .clock      (clock),
         .advance    (advance),
         .taps       (lane_tap[ch]),
         .coef       (coef_ff),
         .norm_shift (norm_ff),
         .result     (lane_res[ch])
      );
   end

   conv5_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (lane_ctl_ff[2]),
      .res_blue  (lane_res[0]),
      .res_green (lane_res[1]),
      .res_red   (lane_res[2]),
      .advance   (advance),
      .rsp       (rsp_bus)
   );
endmodule

/* rtl/core/conv5_ram.sv */
module conv5_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/core/conv5_lane.sv */
module conv5_lane (
   input  logic                    clock,
   input  logic                    advance,
   input  conv5_pkg::chan_type     taps [conv5_pkg::KSIZE][conv5_pkg::KSIZE],
   input  conv5_pkg::coef_row_type coef [conv5_pkg::KSIZE],
   input  logic [conv5_pkg::SHIFT_W-1:0] norm_shift,
   output conv5_pkg::chan_type     result
);
   import conv5_pkg::*;

   logic signed [PROD_W-1:0] prod_ff [KSIZE][KSIZE];
   logic signed [PROD_W-1:0] prod_in [KSIZE][KSIZE];
   logic signed [RSUM_W-1:0] rsum_ff [KSIZE];
   logic signed [RSUM_W-1:0] rsum_in [KSIZE];
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic [14:0]              half;
   logic signed [SUM_W:0]    rounded;
   logic [SUM_W:0]           shifted;

   always_comb begin
      for (int kr = 0; kr < KSIZE; kr++) begin
         for (int kc = 0; kc < KSIZE; kc++) begin
            prod_in[kr][kc] = PROD_W'($signed(coef[kr][COEF_W*kc +: COEF_W])
                                      * $signed({1'b0, taps[kr][kc]}));
         end
      end
      for (int kr = 0; kr < KSIZE; kr++) begin
         rsum_in[kr] = '0;
         for (int kc = 0; kc < KSIZE; kc++) begin
            rsum_in[kr] = rsum_in[kr] + RSUM_W'(prod_ff[kr][kc]);
         end
      end
      sum_in = '0;
      for (int kr = 0; kr < KSIZE; kr++) begin
         sum_in = sum_in + SUM_W'(rsum_ff[kr]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         rsum_ff <= rsum_in;
         sum_ff  <= sum_in;
      end
   end

   always_comb begin
      half    = (norm_shift == '0) ? '0 : (15'd1 << (norm_shift - 4'd1));
      rounded = $signed({sum_ff[SUM_W-1], sum_ff})
              + $signed({{(SUM_W + 1 - 15){1'b0}}, half});
      shifted = $unsigned(rounded) >> norm_shift;
      if (rounded[SUM_W]) begin
         result = '0;
      end else if (|shifted[SUM_W:CH_W]) begin
         result = CH_W'(PIX_MAX);
      end else begin
         result = shifted[CH_W-1:0];
      end
   end
endmodule

/* rtl/core/conv5_merge.sv */
module conv5_merge (
   input  logic                clock,
   input  logic                reset,
   input  conv5_pkg::ctl_type  ctl,
   input  conv5_pkg::chan_type res_blue,
   input  conv5_pkg::chan_type res_green,
   input  conv5_pkg::chan_type res_red,
   output logic                advance,
   conv5_rsp_if.source         rsp
);
   import conv5_pkg::*;

   logic     valid_ff, valid_in;
   logic     last_ff;
   chan_type blue_ff, green_ff, red_ff;

   assign advance  = !valid_ff || rsp.ready;
   assign valid_in = advance ? ctl.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         last_ff  <= ctl.last;
         blue_ff  <= res_blue;
         green_ff <= res_green;
         red_ff   <= res_red;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.out_blue  = blue_ff;
   assign rsp.out_green = green_ff;
   assign rsp.out_red   = red_ff;
   assign rsp.frame_end = last_ff;
endmodule

/* rtl/core/conv5_chk.sv */
module conv5_chk (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input conv5_pkg::chan_type rsp_blue,
   input conv5_pkg::chan_type rsp_green,
   input conv5_pkg::chan_type rsp_red,
   input logic                rsp_last
);
   import conv5_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_blue) && $stable(rsp_green)
                                  && $stable(rsp_red) && $stable(rsp_last))
      else $error("stalled result word changed");

   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input blocked without output stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind conv5x5_rgb_replicate_top conv5_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_blue  (rsp_bus.out_blue),
   .rsp_green (rsp_bus.out_green),
   .rsp_red   (rsp_bus.out_red),
   .rsp_last  (rsp_bus.frame_end)
);
